// ----- rtl/frame_coordinate_transform_core_assert.svh -----
// Assertion macros for the frame coordinate transform core.
`ifndef FRAME_COORDINATE_TRANSFORM_CORE_ASSERT_SVH
`define FRAME_COORDINATE_TRANSFORM_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define FCT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("fct: property violated");

// Condition must never be seen outside reset.
`define FCT_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("fct: forbidden condition");

`else

`define FCT_ASSERT(label, clk, rst_n, prop)
`define FCT_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- rtl/fct_pkg.sv -----
// Shared types, constants and width helpers of the frame coordinate transform.
`timescale 1ns / 1ps

package fct_pkg;

  localparam int REG_WIDTH = 60;
  localparam int IDX_WIDTH = 3;
  localparam int LANES     = 3;
  localparam int FRAC_BITS = 16;
  localparam int QUOT_BITS = 32;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_BASIS_FIRST  = 3'd0,
    REG_BASIS_SECOND = 3'd1,
    REG_BASIS_THIRD  = 3'd2,
    REG_FRAME_ORIGIN = 3'd3
  } reg_idx_e;

  localparam logic [REG_WIDTH-1:0] RST_BASIS_FIRST  = 60'd4096;
  localparam logic [REG_WIDTH-1:0] RST_BASIS_SECOND = 60'd17179869184;
  localparam logic [REG_WIDTH-1:0] RST_BASIS_THIRD  = 60'd4503599627370496;
  localparam logic [REG_WIDTH-1:0] RST_FRAME_ORIGIN = 60'd0;

  localparam logic [QUOT_BITS-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [QUOT_BITS-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic det_zero;
    logic det_neg;
  } frame_stat_t;

  typedef struct packed {
    logic num_neg;
    logic sat;
  } lane_ctl_t;

  // Width of a cross product component, capped at the 64-bit wrap.
  function automatic int cross_w(int cw);
    return (2 * cw + 1 > 64) ? 64 : 2 * cw + 1;
  endfunction

  // Width of a cross component times a difference component.
  function automatic int prod_w(int cw);
    return (cross_w(cw) + cw + 1 > 64) ? 64 : cross_w(cw) + cw + 1;
  endfunction

  // Width of a three-term dot product.
  function automatic int num_w(int cw);
    return (prod_w(cw) + 2 > 64) ? 64 : prod_w(cw) + 2;
  endfunction

  // Register image zero-extended so every component slice exists.
  function automatic int ext_w(int cw);
    return (3 * cw > REG_WIDTH) ? 3 * cw : REG_WIDTH;
  endfunction

endpackage

// ----- rtl/fct_frame.sv -----
// Frame registers and the per-frame precompute: cross products and |det|.
`timescale 1ns / 1ps

module fct_frame #(
  parameter int CW = 20
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [fct_pkg::IDX_WIDTH-1:0]           cfg_idx_i,
  input  logic [fct_pkg::REG_WIDTH-1:0]           cfg_data_i,
  output logic [2:0][CW-1:0]                      origin_o,
  output logic [2:0][2:0][fct_pkg::cross_w(CW)-1:0] cross_o,
  output logic [fct_pkg::num_w(CW)-1:0]           det_mag_o,
  output fct_pkg::frame_stat_t                    stat_o
);

  localparam int XW = fct_pkg::cross_w(CW);
  localparam int PW = fct_pkg::prod_w(CW);
  localparam int NW = fct_pkg::num_w(CW);
  localparam int EW = fct_pkg::ext_w(CW);

  logic [fct_pkg::REG_WIDTH-1:0] bfirst_q, bsecond_q, bthird_q, origin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bfirst_q  <= fct_pkg::RST_BASIS_FIRST;
      bsecond_q <= fct_pkg::RST_BASIS_SECOND;
      bthird_q  <= fct_pkg::RST_BASIS_THIRD;
      origin_q  <= fct_pkg::RST_FRAME_ORIGIN;
    end else if (cfg_we_i) begin
      case (fct_pkg::reg_idx_e'(cfg_idx_i))
        fct_pkg::REG_BASIS_FIRST:  bfirst_q  <= cfg_data_i;
        fct_pkg::REG_BASIS_SECOND: bsecond_q <= cfg_data_i;
        fct_pkg::REG_BASIS_THIRD:  bthird_q  <= cfg_data_i;
        fct_pkg::REG_FRAME_ORIGIN: origin_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack x/y/z; components past bit 59 read as zero.
  logic [EW-1:0]        ext [4];
  logic signed [CW-1:0] comp [4][3];

  assign ext[0] = EW'(bfirst_q);
  assign ext[1] = EW'(bsecond_q);
  assign ext[2] = EW'(bthird_q);
  assign ext[3] = EW'(origin_q);

  for (genvar r = 0; r < 4; r++) begin : g_unpack
    for (genvar k = 0; k < 3; k++) begin : g_comp
      assign comp[r][k] = $signed(ext[r][k*CW +: CW]);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_origin
    assign origin_o[k] = comp[3][k];
  end

  // Cross products: c0 = b1 x b2, c1 = b2 x b0, c2 = b0 x b1.
  logic signed [XW-1:0] cross_q [3][3];

  for (genvar i = 0; i < 3; i++) begin : g_cross
    for (genvar k = 0; k < 3; k++) begin : g_cc
      logic signed [2*CW-1:0] pa, pb;
      logic signed [2*CW:0]   df;
      assign pa = comp[(i+1)%3][(k+1)%3] * comp[(i+2)%3][(k+2)%3];
      assign pb = comp[(i+1)%3][(k+2)%3] * comp[(i+2)%3][(k+1)%3];
      assign df = pa - pb;
      always_ff @(posedge clk_i) begin
        cross_q[i][k] <= XW'(df);
      end
      assign cross_o[i][k] = cross_q[i][k];
    end
  end

  // det = b0 . c0, then its magnitude and flags.
  logic signed [PW-1:0] dprod_d [3];
  logic signed [PW-1:0] dprod_q [3];
  logic signed [NW-1:0] det_d, det_q;
  logic [NW-1:0]        det_mag_q;
  fct_pkg::frame_stat_t stat_q;

  for (genvar k = 0; k < 3; k++) begin : g_dprod
    assign dprod_d[k] = comp[0][k] * cross_q[0][k];
  end

  assign det_d = dprod_q[0] + dprod_q[1] + dprod_q[2];

  always_ff @(posedge clk_i) begin
    dprod_q         <= dprod_d;
    det_q           <= det_d;
    det_mag_q       <= det_q[NW-1] ? NW'(-det_q) : NW'(det_q);
    stat_q.det_zero <= (det_q == '0);
    stat_q.det_neg  <= det_q[NW-1];
  end

  assign det_mag_o = det_mag_q;
  assign stat_o    = stat_q;

endmodule

// ----- rtl/fct_numer.sv -----
// Front pipeline: offset, dot products with the cofactor rows, magnitude, overflow check.
`timescale 1ns / 1ps

module fct_numer #(
  parameter int CW = 20
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic [2:0][CW-1:0]                        point_i,
  input  logic [2:0][CW-1:0]                        origin_i,
  input  logic [2:0][2:0][fct_pkg::cross_w(CW)-1:0] cross_i,
  input  logic [fct_pkg::num_w(CW)-1:0]             det_mag_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [2:0][fct_pkg::num_w(CW)-1:0]        rem_o,
  output logic [2:0][fct_pkg::FRAC_BITS-1:0]        lo_o,
  output fct_pkg::lane_ctl_t [2:0]                  ctl_o
);

  localparam int PW = fct_pkg::prod_w(CW);
  localparam int NW = fct_pkg::num_w(CW);
  localparam int FB = fct_pkg::FRAC_BITS;
  localparam int NS = 5;

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  assign rdy[NS] = out_ready_i;
  for (genvar s = 0; s < NS; s++) begin : g_rdy
    assign rdy[s] = !v_q[s] || rdy[s+1];
  end
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) begin
          v_q[s] <= (s == 0) ? in_valid_i : v_q[s-1];
        end
      end
    end
  end

  // stage 1: d = p - o
  logic signed [CW:0] d_d [3];
  logic signed [CW:0] d_q [3];
  for (genvar k = 0; k < 3; k++) begin : g_d
    assign d_d[k] = $signed(point_i[k]) - $signed(origin_i[k]);
  end
  always_ff @(posedge clk_i) begin
    if (rdy[0]) d_q <= d_d;
  end

  // stage 2: products, numerator i = c_i . d
  logic signed [PW-1:0] prod_d [3][3];
  logic signed [PW-1:0] prod_q [3][3];
  for (genvar i = 0; i < 3; i++) begin : g_prod
    for (genvar k = 0; k < 3; k++) begin : g_pk
      assign prod_d[i][k] = $signed(cross_i[i][k]) * d_q[k];
    end
  end
  always_ff @(posedge clk_i) begin
    if (rdy[1]) prod_q <= prod_d;
  end

  // stage 3: sums
  logic signed [NW-1:0] num_d [3];
  logic signed [NW-1:0] num_q [3];
  for (genvar i = 0; i < 3; i++) begin : g_num
    assign num_d[i] = prod_q[i][0] + prod_q[i][1] + prod_q[i][2];
  end
  always_ff @(posedge clk_i) begin
    if (rdy[2]) num_q <= num_d;
  end

  // stage 4: sign and magnitude
  logic [NW-1:0] mag_q [3];
  logic [2:0]    neg_q;
  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= num_q[i][NW-1];
        mag_q[i] <= num_q[i][NW-1] ? NW'(-num_q[i]) : NW'(num_q[i]);
      end
    end
  end

  // stage 5: quotient overflows 32 bits when mag >= |det| * 2^16;
  // otherwise the top bits of mag seed the remainder.
  logic [2:0][NW-1:0]          rem_q;
  logic [2:0][FB-1:0]          lo_q;
  fct_pkg::lane_ctl_t [2:0]    ctl_q;
  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[i]         <= mag_q[i] >> FB;
        lo_q[i]          <= mag_q[i][FB-1:0];
        ctl_q[i].num_neg <= neg_q[i];
        ctl_q[i].sat     <= ((NW+FB)'(mag_q[i]) >= {det_mag_i, {FB{1'b0}}});
      end
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign rem_o       = rem_q;
  assign lo_o        = lo_q;
  assign ctl_o       = ctl_q;

endmodule

// ----- rtl/fct_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, three lanes sharing one divisor.
`timescale 1ns / 1ps

module fct_div #(
  parameter int NW = 42
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [2:0][NW-1:0]                     rem_i,
  input  logic [2:0][fct_pkg::FRAC_BITS-1:0]     lo_i,
  input  fct_pkg::lane_ctl_t [2:0]               ctl_i,
  input  logic [NW-1:0]                          det_mag_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [2:0][fct_pkg::QUOT_BITS-1:0]     quot_o,
  output fct_pkg::lane_ctl_t [2:0]               ctl_o
);

  localparam int FB = fct_pkg::FRAC_BITS;
  localparam int QB = fct_pkg::QUOT_BITS;
  localparam int NS = QB;

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  assign rdy[NS] = out_ready_i;
  for (genvar s = 0; s < NS; s++) begin : g_rdy
    assign rdy[s] = !v_q[s] || rdy[s+1];
  end
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) begin
          v_q[s] <= (s == 0) ? in_valid_i : v_q[s-1];
        end
      end
    end
  end

  logic [NW-1:0]      src_rem [NS+1][3];
  logic [FB-1:0]      src_lo  [NS+1][3];
  logic [QB-1:0]      src_q   [NS+1][3];
  fct_pkg::lane_ctl_t src_ctl [NS+1][3];

  for (genvar i = 0; i < 3; i++) begin : g_src
    assign src_rem[0][i] = rem_i[i];
    assign src_lo[0][i]  = lo_i[i];
    assign src_q[0][i]   = '0;
    assign src_ctl[0][i] = ctl_i[i];
  end

  for (genvar s = 0; s < NS; s++) begin : g_step
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [NW:0]   shifted;
      logic          take;
      logic [NW-1:0] rem_q;
      logic [FB-1:0] lo_q;
      logic [QB-1:0] q_q;
      fct_pkg::lane_ctl_t ctl_q;

      // bring down the next dividend bit, subtract if it fits
      assign shifted = {src_rem[s][i], src_lo[s][i][FB-1]};
      assign take    = (shifted >= {1'b0, det_mag_i});

      always_ff @(posedge clk_i) begin
        if (rdy[s]) begin
          rem_q <= take ? NW'(shifted - {1'b0, det_mag_i}) : NW'(shifted);
          lo_q  <= {src_lo[s][i][FB-2:0], 1'b0};
          q_q   <= {src_q[s][i][QB-2:0], take};
          ctl_q <= src_ctl[s][i];
        end
      end

      assign src_rem[s+1][i] = rem_q;
      assign src_lo[s+1][i]  = lo_q;
      assign src_q[s+1][i]   = q_q;
      assign src_ctl[s+1][i] = ctl_q;
    end
  end

  assign out_valid_o = v_q[NS-1];
  for (genvar i = 0; i < 3; i++) begin : g_out
    assign quot_o[i] = src_q[NS][i];
    assign ctl_o[i]  = src_ctl[NS][i];
  end

endmodule

// ----- rtl/frame_coordinate_transform_core.sv -----
// Top level of the frame coordinate transform core.
`timescale 1ns / 1ps
`include "frame_coordinate_transform_core_assert.svh"

// Maps a Cartesian Q8.12 point into the frame given by three basis vectors
// and an origin, returning Q16.16 coordinates by Cramer's rule, truncated
// toward zero and saturated to 32 bits; a zero determinant raises singular
// and returns zeros. The block takes one point per clock unless the output
// stalls: from input transfer to output valid the point passes five front
// stages (offset, products, sums, magnitude, overflow check), 32 divider
// stages that each settle one quotient bit, and the output register, the
// first of these 38 registers loading at the transfer edge itself. A stalled
// output backs up stage by stage, so bubbles are squeezed out and in_ready_o
// stays high whenever any stage is free. After a write, the frame's cofactor
// rows and |det| are rebuilt from the registers through the cross product,
// dot product, sum and magnitude registers.
module frame_coordinate_transform_core #(
  parameter int COORD_WIDTH = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fct_pkg::IDX_WIDTH-1:0]     cfg_idx_i,
  input  logic [fct_pkg::REG_WIDTH-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]     point_x_i,
  input  logic signed [COORD_WIDTH-1:0]     point_y_i,
  input  logic signed [COORD_WIDTH-1:0]     point_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [fct_pkg::QUOT_BITS-1:0] coord_first_o,
  output logic signed [fct_pkg::QUOT_BITS-1:0] coord_second_o,
  output logic signed [fct_pkg::QUOT_BITS-1:0] coord_third_o,
  output logic                              singular_o
);

  localparam int CW = COORD_WIDTH;
  localparam int XW = fct_pkg::cross_w(CW);
  localparam int NW = fct_pkg::num_w(CW);
  localparam int FB = fct_pkg::FRAC_BITS;
  localparam int QB = fct_pkg::QUOT_BITS;

  logic [2:0][CW-1:0]        origin;
  logic [2:0][2:0][XW-1:0]   cross_rows;
  logic [NW-1:0]             det_mag;
  fct_pkg::frame_stat_t      stat;

  fct_frame #(.CW(CW)) u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .origin_o  (origin),
    .cross_o   (cross_rows),
    .det_mag_o (det_mag),
    .stat_o    (stat)
  );

  logic [2:0][CW-1:0]       point;
  logic                     num_valid, num_ready;
  logic [2:0][NW-1:0]       num_rem;
  logic [2:0][FB-1:0]       num_lo;
  fct_pkg::lane_ctl_t [2:0] num_ctl;

  assign point[0] = point_x_i;
  assign point[1] = point_y_i;
  assign point[2] = point_z_i;

  fct_numer #(.CW(CW)) u_numer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .point_i    (point),
    .origin_i   (origin),
    .cross_i    (cross_rows),
    .det_mag_i  (det_mag),
    .out_valid_o(num_valid),
    .out_ready_i(num_ready),
    .rem_o      (num_rem),
    .lo_o       (num_lo),
    .ctl_o      (num_ctl)
  );

  logic                     div_valid, div_ready;
  logic [2:0][QB-1:0]       div_quot;
  fct_pkg::lane_ctl_t [2:0] div_ctl;

  fct_div #(.NW(NW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (num_valid),
    .in_ready_o (num_ready),
    .rem_i      (num_rem),
    .lo_i       (num_lo),
    .ctl_i      (num_ctl),
    .det_mag_i  (det_mag),
    .out_valid_o(div_valid),
    .out_ready_i(div_ready),
    .quot_o     (div_quot),
    .ctl_o      (div_ctl)
  );

  // Output register: sign, saturation and the singular override.
  logic              out_v_q;
  logic [2:0][QB-1:0] coord_d;
  logic [2:0][QB-1:0] coord_q;
  logic              singular_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (stat.det_zero) begin
        coord_d[i] = '0;
      end else if (div_ctl[i].num_neg ^ stat.det_neg) begin
        coord_d[i] = (div_ctl[i].sat || div_quot[i] > fct_pkg::SAT_NEG) ?
                     fct_pkg::SAT_NEG : QB'(-div_quot[i]);
      end else begin
        coord_d[i] = (div_ctl[i].sat || div_quot[i] > fct_pkg::SAT_POS) ?
                     fct_pkg::SAT_POS : div_quot[i];
      end
    end
  end

  assign div_ready = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (div_ready) begin
      out_v_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ready) begin
      coord_q    <= coord_d;
      singular_q <= stat.det_zero;
    end
  end

  assign out_valid_o    = out_v_q;
  assign coord_first_o  = coord_q[0];
  assign coord_second_o = coord_q[1];
  assign coord_third_o  = coord_q[2];
  assign singular_o     = singular_q;

  // An empty output register means the whole pipeline can move.
  `FCT_ASSERT(a_ready_when_out_empty, clk_i, rst_ni, !out_v_q |-> in_ready_o)
  // A singular frame always reports zero coordinates.
  `FCT_ASSERT(a_singular_zero, clk_i, rst_ni, out_v_q && singular_q |-> coord_q == '0)
  // Taken output with nothing arriving leaves the register empty.
  `FCT_ASSERT(a_drain, clk_i, rst_ni, out_v_q && out_ready_i && !div_valid |=> !out_v_q)
  // A fresh result on a held output is never loaded over it.
  `FCT_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, out_v_q && !out_ready_i && div_ready)

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the frame coordinate transform core.
`timescale 1ns / 1ps

module tb_top;

  localparam int CW        = 20;
  localparam int LATENCY   = 37;
  localparam int WDOG_MAX  = 20000;
  localparam int PHASE_PTS = 45;
  localparam int RW        = fct_pkg::REG_WIDTH;
  localparam int IW        = fct_pkg::IDX_WIDTH;
  localparam int QB        = fct_pkg::QUOT_BITS;

  // Index past the register file; a write there must be dropped.
  localparam logic [IW-1:0] IDX_UNUSED = 3'd6;

  localparam logic signed [CW-1:0] C_MAX  = 20'sh7FFFF;
  localparam logic signed [CW-1:0] C_MIN  = 20'sh80000;
  localparam logic signed [CW-1:0] C_ONE  = 20'sd4096;
  localparam logic signed [CW-1:0] C_LSB  = 20'sd1;
  localparam logic signed [CW-1:0] C_ZERO = 20'sd0;

  typedef struct {
    logic signed [CW-1:0] x, y, z;
  } point_t;

  typedef struct {
    logic signed [QB-1:0] first, second, third;
    logic                 sing;
  } coord_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IW-1:0] cfg_idx_i = '0;
  logic [RW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CW-1:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [QB-1:0] coord_first_o, coord_second_o, coord_third_o;
  logic singular_o;

  frame_coordinate_transform_core #(.COORD_WIDTH(CW)) dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Shadow copy of the frame registers
  logic [RW-1:0] frame_regs [4];

  point_t pending_points[$];
  coord_t expected_coords[$];
  int     errors = 0;
  bit     rx_calm = 1'b0;

  function automatic longint comp_of(logic [RW-1:0] r, int k);
    logic signed [CW-1:0] c;
    c = r[k*CW +: CW];
    return longint'(c);
  endfunction

  // num * 2^16 / den, truncated toward zero, clamped to 32 bits
  function automatic logic signed [QB-1:0] scaled_quot(longint num, longint den);
    logic signed [127:0] n, d, q;
    n = num;
    d = den;
    n = n <<< fct_pkg::FRAC_BITS;
    q = n / d;
    if (q > 128'sh7FFF_FFFF) return fct_pkg::SAT_POS;
    if (q < -128'sh8000_0000) return fct_pkg::SAT_NEG;
    return q[QB-1:0];
  endfunction

  function automatic coord_t frame_coords(point_t p);
    longint b0[3], b1[3], b2[3], d[3], c[3];
    longint det, n0, n1, n2;
    coord_t r;
    for (int k = 0; k < 3; k++) begin
      b0[k] = comp_of(frame_regs[fct_pkg::REG_BASIS_FIRST], k);
      b1[k] = comp_of(frame_regs[fct_pkg::REG_BASIS_SECOND], k);
      b2[k] = comp_of(frame_regs[fct_pkg::REG_BASIS_THIRD], k);
    end
    d[0] = longint'(p.x) - comp_of(frame_regs[fct_pkg::REG_FRAME_ORIGIN], 0);
    d[1] = longint'(p.y) - comp_of(frame_regs[fct_pkg::REG_FRAME_ORIGIN], 1);
    d[2] = longint'(p.z) - comp_of(frame_regs[fct_pkg::REG_FRAME_ORIGIN], 2);
    // b1 x b2
    c[0] = b1[1] * b2[2] - b1[2] * b2[1];
    c[1] = b1[2] * b2[0] - b1[0] * b2[2];
    c[2] = b1[0] * b2[1] - b1[1] * b2[0];
    det = b0[0] * c[0] + b0[1] * c[1] + b0[2] * c[2];
    if (det == 0) begin
      r.first = '0; r.second = '0; r.third = '0; r.sing = 1'b1;
      return r;
    end
    n0 = c[0] * d[0] + c[1] * d[1] + c[2] * d[2];
    // b0 . (d x b2)
    n1 = b0[0] * (d[1] * b2[2] - d[2] * b2[1]) + b0[1] * (d[2] * b2[0] - d[0] * b2[2])
       + b0[2] * (d[0] * b2[1] - d[1] * b2[0]);
    // b0 . (b1 x d)
    n2 = b0[0] * (b1[1] * d[2] - b1[2] * d[1]) + b0[1] * (b1[2] * d[0] - b1[0] * d[2])
       + b0[2] * (b1[0] * d[1] - b1[1] * d[0]);
    r.first  = scaled_quot(n0, det);
    r.second = scaled_quot(n1, det);
    r.third  = scaled_quot(n2, det);
    r.sing   = 1'b0;
    return r;
  endfunction

  function automatic logic [RW-1:0] pack_vec(logic signed [CW-1:0] x,
                                             logic signed [CW-1:0] y,
                                             logic signed [CW-1:0] z);
    return {z, y, x};
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return C_MAX;
      1: return C_MIN;
      2: return CW'($urandom_range(0, 16383) - 8192);
      3: return CW'(C_ONE * ($urandom_range(0, 8) - 4));
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic [RW-1:0] rand_reg();
    return RW'({$urandom, $urandom});
  endfunction

  task automatic queue_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                             logic signed [CW-1:0] z);
    point_t p;
    p.x = x; p.y = y; p.z = z;
    pending_points.push_back(p);
  endtask

  task automatic cfg_write(logic [IW-1:0] idx, logic [RW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx <= fct_pkg::REG_FRAME_ORIGIN) frame_regs[idx[1:0]] = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_frame(logic [RW-1:0] f0, logic [RW-1:0] f1,
                           logic [RW-1:0] f2, logic [RW-1:0] org);
    cfg_write(fct_pkg::REG_BASIS_FIRST, f0);
    cfg_write(fct_pkg::REG_BASIS_SECOND, f1);
    cfg_write(fct_pkg::REG_BASIS_THIRD, f2);
    cfg_write(fct_pkg::REG_FRAME_ORIGIN, org);
    repeat (8) @(posedge clk_i);
  endtask

  // Wait until every queued point is sent and every expected result is back, then let the pipe settle
  task automatic drain();
    while (pending_points.size() != 0 || in_valid_i || expected_coords.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic random_points(int n);
    for (int i = 0; i < n; i++) queue_point(rand_coord(), rand_coord(), rand_coord());
  endtask

  // Driver: bursts of transfers separated by random gaps
  int burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        point_t p;
        p.x = point_x_i; p.y = point_y_i; p.z = point_z_i;
        expected_coords.push_back(frame_coords(p));
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_points.size() != 0) begin
          point_t p;
          p = pending_points.pop_front();
          point_x_i  <= p.x;
          point_y_i  <= p.y;
          point_z_i  <= p.z;
          in_valid_i <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: occasional stalls of random length
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!rx_calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 15);
    end
  end

  // Monitor: compare each transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_coords.size() == 0) begin
        $display("%0t: unexpected result transfer", $realtime);
        errors++;
      end else begin
        coord_t e;
        e = expected_coords.pop_front();
        if (coord_first_o !== e.first) begin
          $display("%0t: coord_first exp %h got %h", $realtime, e.first, coord_first_o);
          errors++;
        end
        if (coord_second_o !== e.second) begin
          $display("%0t: coord_second exp %h got %h", $realtime, e.second, coord_second_o);
          errors++;
        end
        if (coord_third_o !== e.third) begin
          $display("%0t: coord_third exp %h got %h", $realtime, e.third, coord_third_o);
          errors++;
        end
        if (singular_o !== e.sing) begin
          $display("%0t: singular exp %b got %b", $realtime, e.sing, singular_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_MAX) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic signed [CW-1:0] a, b, c;
    frame_regs[fct_pkg::REG_BASIS_FIRST]  = fct_pkg::RST_BASIS_FIRST;
    frame_regs[fct_pkg::REG_BASIS_SECOND] = fct_pkg::RST_BASIS_SECOND;
    frame_regs[fct_pkg::REG_BASIS_THIRD]  = fct_pkg::RST_BASIS_THIRD;
    frame_regs[fct_pkg::REG_FRAME_ORIGIN] = fct_pkg::RST_FRAME_ORIGIN;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (8) @(posedge clk_i);

    // Directed: reset frame, field extremes, zero, the origin itself
    rx_calm = 1'b1;
    queue_point(C_ZERO, C_ZERO, C_ZERO);
    queue_point(C_MAX, C_MAX, C_MAX);
    queue_point(C_MIN, C_MIN, C_MIN);
    queue_point(C_MAX, C_MIN, C_ZERO);
    queue_point(C_ONE, -C_ONE, C_ONE);
    queue_point(-C_LSB, C_LSB, -C_LSB);
    queue_point(20'sh55555, 20'shAAAAA, 20'sh0F0F0);
    drain();
    rx_calm = 1'b0;

    // Tiny unit basis: quotients saturate both ways
    set_frame(pack_vec(C_LSB, C_ZERO, C_ZERO), pack_vec(C_ZERO, C_LSB, C_ZERO),
              pack_vec(C_ZERO, C_ZERO, C_LSB), '0);
    queue_point(C_MAX, C_MIN, C_LSB);
    queue_point(C_MIN, C_MAX, -C_LSB);
    queue_point(C_ZERO, C_ZERO, C_ZERO);
    random_points(PHASE_PTS);
    drain();

    // Singular: repeated basis vector, then a zero basis vector
    a = rand_coord(); b = rand_coord(); c = rand_coord();
    set_frame(pack_vec(a, b, c), RW'($urandom), pack_vec(a, b, c), RW'($urandom));
    queue_point(C_MAX, C_MAX, C_MAX);
    random_points(20);
    drain();
    set_frame(RW'($urandom), '0, RW'($urandom), RW'($urandom));
    random_points(20);
    drain();

    // Extreme frames: max axes with min origin, min axes with max origin, then mixed extremes with an all-ones origin
    set_frame(pack_vec(C_MAX, C_ZERO, C_ZERO), pack_vec(C_ZERO, C_MAX, C_ZERO),
              pack_vec(C_ZERO, C_ZERO, C_MAX), pack_vec(C_MIN, C_MIN, C_MIN));
    queue_point(C_MAX, C_MAX, C_MAX);
    random_points(PHASE_PTS);
    drain();
    set_frame(pack_vec(C_MIN, C_ZERO, C_ZERO), pack_vec(C_ZERO, C_MIN, C_ZERO),
              pack_vec(C_ZERO, C_ZERO, C_MIN), pack_vec(C_MAX, C_MAX, C_MAX));
    queue_point(C_MIN, C_MIN, C_MIN);
    random_points(PHASE_PTS);
    drain();
    set_frame({RW{1'b1}}, pack_vec(C_MIN, C_MAX, C_LSB),
              pack_vec(C_MAX, 20'sd3, C_MIN), {RW{1'b1}});
    random_points(PHASE_PTS);
    drain();

    // Random frames, full range and near-unit scale
    for (int ph = 0; ph < 4; ph++) begin
      if (ph[0])
        set_frame(rand_reg(), rand_reg(), rand_reg(), rand_reg());
      else
        set_frame(pack_vec(rand_coord(), rand_coord(), rand_coord()),
                  pack_vec(rand_coord(), rand_coord(), rand_coord()),
                  pack_vec(rand_coord(), rand_coord(), rand_coord()),
                  pack_vec(rand_coord(), rand_coord(), rand_coord()));
      // Out of range index must leave the frame alone
      if (ph == 2) cfg_write(IDX_UNUSED, {RW{1'b1}});
      random_points(PHASE_PTS);
      drain();
    end

    // Back to the reset frame, written explicitly
    set_frame(fct_pkg::RST_BASIS_FIRST, fct_pkg::RST_BASIS_SECOND,
              fct_pkg::RST_BASIS_THIRD, fct_pkg::RST_FRAME_ORIGIN);
    random_points(PHASE_PTS);
    drain();

    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0 && expected_coords.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
